// ===== rtl/sixb_pkg.sv =====
// Shared types and constants for the six-bit text encoder.
// No dependencies; imported by every module of the block.
`default_nettype none
package sixb_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned GroupW = 6;
  localparam int unsigned CharW  = 7;
  localparam int unsigned CountW = 16;

  localparam logic [CharW-1:0]  CharOffset = 7'h3C;
  localparam logic [CountW-1:0] LimitReset = 16'hFFFF;

  typedef struct packed {
    logic [CharW-1:0] code_char;
    logic             empty_res;
    logic             run_end;
  } res_t;

  typedef struct packed {
    res_t       r0;
    res_t       r1;
    logic [1:0] num;
  } res_pair_t;

endpackage
`default_nettype wire

// ===== rtl/sixb_enc.sv =====
// Encoding datapath: holds leftover bits, phase, character count and limit.
// Turns one byte into up to two results. Depends on sixb_pkg.
`default_nettype none
module sixb_enc
  import sixb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [CountW-1:0] cfg_limit,
  input  wire logic              advance,
  input  wire logic [ByteW-1:0]  data_byte,
  input  wire logic              final_byte,
  output res_pair_t              res
);

  logic [CountW-1:0] output_limit;
  logic [GroupW-1:0] leftover_bits, leftover_bits_next;
  logic [1:0]        phase, phase_next;
  logic [CountW-1:0] emitted_count, emitted_count_next;

  always_comb begin
    logic [1:0]        p;
    logic [GroupW-1:0] made, rest;
    logic [GroupW-1:0] ch0, ch1;
    logic [1:0]        n;
    logic [CountW-1:0] cnt;

    p = (phase == 2'd3) ? 2'd2 : phase;
    case (p)
      2'd0: begin
        made = data_byte[7:2];
        rest = {data_byte[1:0], 4'b0};
      end
      2'd1: begin
        made = leftover_bits | {2'b0, data_byte[7:4]};
        rest = {data_byte[3:0], 2'b0};
      end
      default: begin
        made = leftover_bits | {4'b0, data_byte[7:6]};
        rest = data_byte[5:0];
      end
    endcase

    ch0 = '0;
    ch1 = '0;
    n = 2'd0;
    cnt = emitted_count;
    leftover_bits_next = leftover_bits;
    phase_next = phase;

    if (emitted_count < output_limit) begin
      ch0 = made;
      n = 2'd1;
      cnt = emitted_count + CountW'(1);
      if (p != 2'd2) begin
        leftover_bits_next = rest;
        phase_next = p + 2'd1;
      end else begin
        if (cnt < output_limit) begin
          ch1 = rest;
          n = 2'd2;
          cnt = cnt + CountW'(1);
        end
        leftover_bits_next = '0;
        phase_next = 2'd0;
      end
    end

    if (final_byte && phase_next != 2'd0 && cnt < output_limit && n != 2'd2) begin
      if (n == 2'd0) begin
        ch0 = leftover_bits_next;
      end else begin
        ch1 = leftover_bits_next;
      end
      n = n + 2'd1;
      cnt = cnt + CountW'(1);
    end

    res.r0.code_char = {1'b0, ch0} + CharOffset;
    res.r0.empty_res = 1'b0;
    res.r0.run_end   = final_byte && (n == 2'd1);
    res.r1.code_char = {1'b0, ch1} + CharOffset;
    res.r1.empty_res = 1'b0;
    res.r1.run_end   = final_byte;
    res.num          = n;

    if (final_byte) begin
      if (n == 2'd0) begin
        res.r0.code_char = '0;
        res.r0.empty_res = 1'b1;
        res.r0.run_end   = 1'b1;
        res.num          = 2'd1;
      end
      leftover_bits_next = '0;
      phase_next = 2'd0;
      cnt = '0;
    end
    emitted_count_next = cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      output_limit  <= LimitReset;
      leftover_bits <= '0;
      phase         <= 2'd0;
      emitted_count <= '0;
    end else begin
      if (cfg_we) begin
        output_limit <= cfg_limit;
      end
      if (advance) begin
        leftover_bits <= leftover_bits_next;
        phase         <= phase_next;
        emitted_count <= emitted_count_next;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sixb_outbuf.sv =====
// Two-entry result buffer: loads a result pair, drains one beat per cycle
// while out_ready is high. Depends on sixb_pkg.
`default_nettype none
module sixb_outbuf
  import sixb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      load,
  input  wire res_pair_t load_res,
  output logic           can_load,
  output logic           out_valid,
  input  wire logic      out_ready,
  output res_t           out_res
);

  res_t       e0, e1;
  logic [1:0] cnt;
  logic       pop;

  assign out_valid = (cnt != 2'd0);
  assign pop       = out_valid && out_ready;
  assign can_load  = (cnt == 2'd0) || (cnt == 2'd1 && out_ready);
  assign out_res   = e0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= load_res.num;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      e0 <= load_res.r0;
      e1 <= load_res.r1;
    end else if (pop) begin
      e0 <= e1;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/six_bit_text_encoder.sv =====
// Six-bit text encoder: packs bytes MSB first into 6-bit printable characters.
// Channels: s_* takes one byte per beat (tlast marks the message's last byte);
// m_* gives one character per beat (tuser flags an empty result, tlast marks
// the last result of a message); cfg_* writes the per-message character limit.
// A byte is held in an input register, encoded combinationally from it into up
// to two results, and those go to a two-entry output buffer. An accepted byte
// goes through the input register and output buffer before its first result.
// Throughput: one byte per cycle while each byte gives at most one result and
// m_tready is high; a byte that gives two results holds back the next byte
// until its first result has left, set by the single output beat per cycle.
// Reset clears the pending bits, phase and count, empties both registers,
// and sets the limit to 65535. cfg_ready is always high.
// When m_tready is low, results hold in the buffer; the input register then
// holds its byte and s_tready drops until the buffer can take its results.
// Dependencies: sixb_pkg, sixb_enc, sixb_outbuf.
`default_nettype none
module six_bit_text_encoder
  import sixb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [6:0] code_char, [7] zero
  output logic [0:0]       m_tuser,   // [0] empty_res
  output logic             m_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  logic             in_valid;
  logic [ByteW-1:0] in_byte;
  logic             in_last;
  logic             advance;
  logic             can_load;
  res_pair_t        pair;
  res_t             out_res;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid && can_load;
  assign s_tready  = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  sixb_enc u_enc (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_limit  (cfg_data),
    .advance    (advance),
    .data_byte  (in_byte),
    .final_byte (in_last),
    .res        (pair)
  );

  sixb_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .load_res  (pair),
    .can_load  (can_load),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = {1'b0, out_res.code_char};
  assign m_tuser = out_res.empty_res;
  assign m_tlast = out_res.run_end;

endmodule
`default_nettype wire
